@@ rtl/btrc_pkg.sv @@
// ----------------------------------------------------------------------------
// btrc_pkg
// Shared constants and codes for the branch target reach checker.
// ----------------------------------------------------------------------------
package btrc_pkg;

	localparam int DEF_MAX_SLOTS  = 512;
	localparam int DEF_SLOT_BYTES = 2;

	localparam int ADDR_W  = 64;
	localparam int KIND_W  = 3;
	localparam int SIZE_W  = 4;
	localparam int STAT_W  = 2;
	localparam int EPOCH_W = 8;
	localparam int PADDR_W = 4;

	localparam logic [EPOCH_W-1:0] EPOCH_FIRST = EPOCH_W'(1);
	localparam logic [EPOCH_W-1:0] EPOCH_LAST  = {EPOCH_W{1'b1}};

	localparam logic OP_START  = 1'b0;
	localparam logic OP_REPORT = 1'b1;

	localparam logic [KIND_W-1:0] KIND_ORDINARY = 3'd0;
	localparam logic [KIND_W-1:0] KIND_PCREL    = 3'd1;
	localparam logic [KIND_W-1:0] KIND_RETURN   = 3'd2;
	localparam logic [KIND_W-1:0] KIND_BRANCH   = 3'd3;

	localparam logic [STAT_W-1:0] STAT_DECODE = 2'd0;
	localparam logic [STAT_W-1:0] STAT_CLEAN  = 2'd1;
	localparam logic [STAT_W-1:0] STAT_HAZARD = 2'd2;
	localparam logic [STAT_W-1:0] STAT_IDLE   = 2'd3;

	// register select bit of paddr (registers lie 8 bytes apart)
	localparam logic REG_PATCH_START = 1'b0;
	localparam logic REG_PATCH_END   = 1'b1;

endpackage

@@ rtl/branch_target_reach_checker.sv @@
// ----------------------------------------------------------------------------
// branch_target_reach_checker
// Worklist engine for a control-flow reachability walk behind a patched
// region; flags branch or pc-relative targets that point back into it.
//
// Channel   Dir  Contents
// s_axis    in   tuser: opcode, report_kind; tdata: target, cond/call, size
// m_axis    out  tuser: status; tdata: next_address
// apb       cfg  patch_start at 0x0, patch_end at 0x8 (64-bit registers)
//
// One transaction at a time. A start moves from idle to the result state; a
// report in a walk runs through exec, then each push through a range check and,
// inside the slot window, a visited-slot RAM read and write, then each pop through
// a stack RAM read and its check. Every 255th start, and once after reset, a
// clearing pass sweeps all MAX_SLOTS visited-slot RAM entries; no input is taken meanwhile.
// A result waits in the output register; while it waits the next transaction
// is still taken, and its result holds the engine until the register frees.
// ----------------------------------------------------------------------------
module branch_target_reach_checker #(
	parameter int MAX_SLOTS  = btrc_pkg::DEF_MAX_SLOTS,
	parameter int SLOT_BYTES = btrc_pkg::DEF_SLOT_BYTES
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          s_axis_tvalid,
	output logic                          s_axis_tready,
	input  logic [71:0]                   s_axis_tdata,  // target[63:0], cond_or_call[64], size[68:65]
	input  logic [3:0]                    s_axis_tuser,  // opcode[0], report_kind[3:1]
	output logic                          m_axis_tvalid,
	input  logic                          m_axis_tready,
	output logic [63:0]                   m_axis_tdata,  // next_address[63:0]
	output logic [1:0]                    m_axis_tuser,  // status[1:0]
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [btrc_pkg::PADDR_W-1:0]  paddr,
	input  logic [63:0]                   pwdata,
	output logic [63:0]                   prdata,
	output logic                          pready
);

	localparam int SW   = $clog2(MAX_SLOTS);
	localparam int CW   = $clog2(MAX_SLOTS + 1);
	localparam int SPAN = MAX_SLOTS * SLOT_BYTES;
	localparam int DW   = $clog2(SPAN);
	localparam int RS   = DW + 2;
	localparam int PW   = DW + RS + 1;
	localparam int RECIP_I = ((2 ** RS) + SLOT_BYTES - 1) / SLOT_BYTES;
	localparam logic [RS:0] RECIP = RECIP_I[RS:0];
	localparam int AW = btrc_pkg::ADDR_W;
	localparam int EW = btrc_pkg::EPOCH_W;

	localparam logic [3:0] ST_CLEAR   = 4'd0;
	localparam logic [3:0] ST_IDLE    = 4'd1;
	localparam logic [3:0] ST_EXEC    = 4'd2;
	localparam logic [3:0] ST_P_RANGE = 4'd3;
	localparam logic [3:0] ST_P_READ  = 4'd4;
	localparam logic [3:0] ST_P_WRITE = 4'd5;
	localparam logic [3:0] ST_POP_RD  = 4'd6;
	localparam logic [3:0] ST_POP_CHK = 4'd7;
	localparam logic [3:0] ST_RESULT  = 4'd8;

	logic [3:0]                        state_q;
	logic [AW-1:0]                     patch_start_q, patch_end_q;
	logic [AW-1:0]                     cur_q, limit_q;
	logic [CW-1:0]                     count_q;
	logic                              walk_q;
	logic [EW-1:0]                     epoch_q;
	logic [SW-1:0]                     clr_idx_q;
	logic                              clr_reply_q;
	logic [btrc_pkg::KIND_W-1:0]       kind_q;
	logic [AW-1:0]                     target_q;
	logic                              falls_q;
	logic [btrc_pkg::SIZE_W-1:0]       size_q;
	logic [AW-1:0]                     push_addr_q, fall_addr_q;
	logic                              fall_pend_q;
	logic [DW-1:0]                     diff_q;
	logic [SW-1:0]                     slot_q;
	logic [btrc_pkg::STAT_W-1:0]       res_status_q, out_status_q;
	logic [AW-1:0]                     res_addr_q, out_addr_q;
	logic                              out_valid_q;

	logic                              cfg_wr, in_fire, out_free, in_patch, nxt_push;
	logic [AW-1:0]                     fall_addr, diff;
	logic                              in_span, is_new, can_store;
	logic [PW-1:0]                     prod;
	logic [SW-1:0]                     slot;
	logic [CW-1:0]                     cnt_dec;
	logic                              vis_we, stk_we;
	logic [SW-1:0]                     vis_waddr;
	logic [EW-1:0]                     vis_wdata, vis_rdata;
	logic [AW-1:0]                     stk_rdata;

	assign pready        = 1'b1;
	assign cfg_wr        = psel & penable & pwrite & pready;
	assign prdata        = (paddr[3] == btrc_pkg::REG_PATCH_END) ? patch_end_q : patch_start_q;
	assign s_axis_tready = (state_q == ST_IDLE);
	assign in_fire       = s_axis_tvalid & s_axis_tready;
	assign out_free      = ~out_valid_q | m_axis_tready;
	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = out_addr_q;
	assign m_axis_tuser  = out_status_q;

	assign in_patch  = (target_q >= patch_start_q) && (target_q < patch_end_q);
	assign fall_addr = cur_q + {{(AW - btrc_pkg::SIZE_W){1'b0}}, size_q};
	assign diff      = push_addr_q - patch_start_q;
	assign in_span   = diff < AW'(SPAN);
	assign prod      = {{(RS + 1){1'b0}}, diff_q} * {{DW{1'b0}}, RECIP};
	assign slot      = prod[RS +: SW];
	assign is_new    = vis_rdata != epoch_q;
	assign can_store = count_q < CW'(MAX_SLOTS);
	assign cnt_dec   = count_q - CW'(1);
	assign nxt_push  = fall_pend_q;

	always_comb begin
		vis_we    = 1'b0;
		vis_waddr = slot_q;
		vis_wdata = epoch_q;
		if (state_q == ST_CLEAR) begin
			vis_we    = 1'b1;
			vis_waddr = clr_idx_q;
			vis_wdata = '0;
		end else if (state_q == ST_P_WRITE && walk_q && is_new) begin
			vis_we = 1'b1;
		end
	end

	assign stk_we = (state_q == ST_P_WRITE) && walk_q && is_new && can_store;

	btrc_ram #(.WIDTH(EW), .DEPTH(MAX_SLOTS)) u_visited (
		.clk   (clk),
		.we    (vis_we),
		.waddr (vis_waddr),
		.wdata (vis_wdata),
		.raddr (slot),
		.rdata (vis_rdata)
	);

	btrc_ram #(.WIDTH(AW), .DEPTH(MAX_SLOTS)) u_stack (
		.clk   (clk),
		.we    (stk_we),
		.waddr (count_q[SW-1:0]),
		.wdata (push_addr_q),
		.raddr (cnt_dec[SW-1:0]),
		.rdata (stk_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= ST_CLEAR;
			patch_start_q <= '0;
			patch_end_q   <= '0;
			cur_q         <= '0;
			limit_q       <= '1;
			count_q       <= '0;
			walk_q        <= 1'b0;
			epoch_q       <= btrc_pkg::EPOCH_FIRST;
			clr_idx_q     <= '0;
			clr_reply_q   <= 1'b0;
			fall_pend_q   <= 1'b0;
			out_valid_q   <= 1'b0;
		end else begin
			if (cfg_wr) begin
				if (paddr[3] == btrc_pkg::REG_PATCH_END) begin
					patch_end_q <= pwdata;
				end else begin
					patch_start_q <= pwdata;
				end
			end
			if (out_valid_q && m_axis_tready && state_q != ST_RESULT) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_CLEAR: begin
					if (clr_idx_q == SW'(MAX_SLOTS - 1)) begin
						clr_idx_q <= '0;
						epoch_q   <= btrc_pkg::EPOCH_FIRST;
						state_q   <= clr_reply_q ? ST_RESULT : ST_IDLE;
					end else begin
						clr_idx_q <= clr_idx_q + SW'(1);
					end
				end
				ST_IDLE: begin
					if (in_fire) begin
						kind_q   <= s_axis_tuser[3:1];
						target_q <= s_axis_tdata[63:0];
						falls_q  <= s_axis_tdata[64];
						size_q   <= s_axis_tdata[68:65];
						if (s_axis_tuser[0] == btrc_pkg::OP_START) begin
							count_q      <= '0;
							limit_q      <= '1;
							cur_q        <= patch_end_q;
							walk_q       <= 1'b1;
							res_status_q <= btrc_pkg::STAT_DECODE;
							res_addr_q   <= patch_end_q;
							if (epoch_q == btrc_pkg::EPOCH_LAST) begin
								clr_reply_q <= 1'b1;
								state_q     <= ST_CLEAR;
							end else begin
								epoch_q <= epoch_q + EW'(1);
								state_q <= ST_RESULT;
							end
						end else if (!walk_q) begin
							res_status_q <= btrc_pkg::STAT_IDLE;
							res_addr_q   <= '0;
							state_q      <= ST_RESULT;
						end else begin
							state_q <= ST_EXEC;
						end
					end
				end
				ST_EXEC: begin
					fall_addr_q <= fall_addr;
					if ((kind_q == btrc_pkg::KIND_PCREL || kind_q == btrc_pkg::KIND_BRANCH)
							&& in_patch) begin
						walk_q       <= 1'b0;
						res_status_q <= btrc_pkg::STAT_HAZARD;
						res_addr_q   <= '0;
						state_q      <= ST_RESULT;
					end else begin
						case (kind_q)
							btrc_pkg::KIND_ORDINARY: begin
								push_addr_q <= fall_addr;
								fall_pend_q <= 1'b0;
								state_q     <= ST_P_RANGE;
							end
							btrc_pkg::KIND_PCREL: begin
								push_addr_q <= fall_addr;
								fall_pend_q <= 1'b0;
								state_q     <= ST_P_RANGE;
							end
							btrc_pkg::KIND_RETURN: begin
								if (limit_q > cur_q) begin
									limit_q <= cur_q;
								end
								fall_pend_q <= 1'b0;
								state_q     <= ST_POP_RD;
							end
							btrc_pkg::KIND_BRANCH: begin
								push_addr_q <= target_q;
								fall_pend_q <= falls_q;
								state_q     <= ST_P_RANGE;
							end
							default: begin
								fall_pend_q <= 1'b0;
								state_q     <= ST_POP_RD;
							end
						endcase
					end
				end
				ST_P_RANGE: begin
					diff_q <= diff[DW-1:0];
					if (in_span) begin
						state_q <= ST_P_READ;
					end else if (nxt_push) begin
						push_addr_q <= fall_addr_q;
						fall_pend_q <= 1'b0;
					end else begin
						state_q <= ST_POP_RD;
					end
				end
				ST_P_READ: begin
					slot_q  <= slot;
					state_q <= ST_P_WRITE;
				end
				ST_P_WRITE: begin
					if (stk_we) begin
						count_q <= count_q + CW'(1);
					end
					if (nxt_push) begin
						push_addr_q <= fall_addr_q;
						fall_pend_q <= 1'b0;
						state_q     <= ST_P_RANGE;
					end else begin
						state_q <= ST_POP_RD;
					end
				end
				ST_POP_RD: begin
					if (count_q == '0) begin
						walk_q       <= 1'b0;
						res_status_q <= btrc_pkg::STAT_CLEAN;
						res_addr_q   <= '0;
						state_q      <= ST_RESULT;
					end else begin
						count_q <= cnt_dec;
						state_q <= ST_POP_CHK;
					end
				end
				ST_POP_CHK: begin
					if (stk_rdata <= limit_q) begin
						cur_q        <= stk_rdata;
						res_status_q <= btrc_pkg::STAT_DECODE;
						res_addr_q   <= stk_rdata;
						state_q      <= ST_RESULT;
					end else begin
						state_q <= ST_POP_RD;
					end
				end
				ST_RESULT: begin
					if (out_free) begin
						out_valid_q  <= 1'b1;
						out_status_q <= res_status_q;
						out_addr_q   <= res_addr_q;
						clr_reply_q  <= 1'b0;
						state_q      <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(MAX_SLOTS))
		else $error("stack count above slot capacity");

	a_epoch_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		epoch_q != '0)
		else $error("epoch zero collides with cleared entries");

	a_push_marks: assert property (@(posedge clk) disable iff (!arst_n)
		stk_we |-> vis_we && vis_wdata == epoch_q)
		else $error("stack push without marking the slot visited");

	a_push_grows: assert property (@(posedge clk) disable iff (!arst_n)
		stk_we |=> count_q == $past(count_q) + CW'(1))
		else $error("stack push lost");

	a_pop_shrinks: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_POP_RD && count_q != '0) |=> state_q == ST_POP_CHK)
		else $error("pop read not followed by its check");

endmodule

@@ rtl/btrc_ram.sv @@
// ----------------------------------------------------------------------------
// btrc_ram
// Generic single write port, single read port RAM with registered read.
// ----------------------------------------------------------------------------
module btrc_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 512
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule
